FILE: design/bkom_pkg.sv
// Package for the bucketed key-to-handle map.
// Holds the request and status codes, the sequencer state type and the slot layout.
// No dependencies.
package bkom_pkg;

    localparam int KEY_W        = 32;
    localparam int HANDLE_W     = 32;
    localparam int BB_W         = 4;
    localparam int MKEY_W       = 15;
    localparam int BB_RESET     = 8;
    localparam int MAX_BUCKETS_DEF = 256;
    localparam int WAYS_DEF     = 4;

    localparam logic [1:0] REQ_FIND   = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_CMP,
        S_DECIDE
    } state_t;

    typedef struct packed {
        logic                valid;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } slot_t;

endpackage

FILE: design/bkom_ram.sv
// Generic single-port-write, registered-read RAM.
// Used for the slot store of the map; no package dependencies.
module bkom_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/bucketed_key_object_map.sv
// Bucketed key-to-handle map: find, add or remove one 32-bit key per request, one
// result word per request. After reset the block sweeps the slot store once, one slot
// a cycle, and takes no request meanwhile. A request then takes one RAM read and one
// compare per way, then a decide and write-back step that waits while the result word
// cannot be loaded; when MAX_BUCKETS is not a power of two, the bucket remainder is
// formed first by a reciprocal multiply and one corrective subtract. No new request is
// taken while one is in progress; the single slot RAM port sets this pace.
// Depends on bkom_pkg and bkom_ram.
module bucketed_key_object_map
    import bkom_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int WAYS        = WAYS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          req_type,
    input  logic [KEY_W-1:0]    key,
    input  logic [HANDLE_W-1:0] object_handle,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [HANDLE_W-1:0] found_handle,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int SLOTS   = MAX_BUCKETS * WAYS;
    localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BKT_W   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int MC_W    = 1;
    localparam bit IS_POW2 = (MAX_BUCKETS & (MAX_BUCKETS - 1)) == 0;
    localparam int SLOT_W  = $bits(slot_t);
    localparam longint unsigned RECIP = 64'h1_0000_0000 / longint'(MAX_BUCKETS);
    localparam logic [31:0] RECIP_K = 32'(RECIP);

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [1:0]           req_reg, req_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [HANDLE_W-1:0]  handle_reg, handle_next;
    logic [MKEY_W-1:0]    mkey_reg, mkey_next;
    logic [MKEY_W-1:0]    quot_reg, quot_next;
    logic [MC_W-1:0]      mod_cnt_reg, mod_cnt_next;
    logic [BKT_W-1:0]     bucket_reg, bucket_next;
    logic [WAY_W-1:0]     way_reg, way_next;
    logic                 hit_reg, hit_next;
    logic [WAY_W-1:0]     hit_way_reg, hit_way_next;
    logic [HANDLE_W-1:0]  hit_handle_reg, hit_handle_next;
    logic                 free_reg, free_next;
    logic [WAY_W-1:0]     free_way_reg, free_way_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           status_reg, status_next;
    logic [HANDLE_W-1:0]  found_handle_reg, found_handle_next;
    logic [BB_W-1:0]      bucket_bits_reg, bucket_bits_next;

    logic                 in_fire;
    logic                 cfg_write;
    logic                 clr_done;
    logic                 mod_done;
    logic                 way_last;
    logic                 out_free;
    logic [15:0]          bb_mask;
    logic [MKEY_W-1:0]    in_mkey;
    logic [MKEY_W+31:0]   mod_prod;
    logic [31:0]          mod_qd;
    logic [MKEY_W-1:0]    mod_diff;
    logic [MKEY_W-1:0]    mod_rem;
    logic [ADDR_W-1:0]    base_addr;
    logic                 slot_match;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    slot_t                ram_wdata;
    slot_t                ram_rdata;
    logic [SLOT_W-1:0]    ram_rdata_raw;

    logic [1:0]           dec_status;
    logic [HANDLE_W-1:0]  dec_handle;
    logic                 dec_we;
    logic [WAY_W-1:0]     dec_way;
    slot_t                dec_slot;

    bkom_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .raddr (ram_addr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = slot_t'(ram_rdata_raw);

    assign in_fire    = in_valid && in_ready;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign clr_done   = clr_cnt_reg == ADDR_W'(SLOTS - 1);
    assign mod_done   = mod_cnt_reg == MC_W'(1);
    assign way_last   = way_reg == WAY_W'(WAYS - 1);
    assign out_free   = !out_valid_reg || out_ready;
    assign bb_mask    = (16'd1 << bucket_bits_reg) - 16'd1;
    assign in_mkey    = key[MKEY_W-1:0] & bb_mask[MKEY_W-1:0];
    assign mod_prod   = (MKEY_W+32)'(mkey_reg) * (MKEY_W+32)'(RECIP_K);
    assign mod_qd     = 32'(quot_reg) * 32'(MAX_BUCKETS);
    assign mod_diff   = mkey_reg - mod_qd[MKEY_W-1:0];
    assign mod_rem    = (32'(mod_diff) >= 32'(MAX_BUCKETS))
                      ? mod_diff - MKEY_W'(MAX_BUCKETS) : mod_diff;
    assign base_addr  = ADDR_W'(bucket_reg) * ADDR_W'(WAYS);
    assign slot_match = ram_rdata.valid && (ram_rdata.key == key_reg);

    assign pready    = 1'b1;
    assign prdata    = paddr[2] ? 32'd0 : {{(32 - BB_W){1'b0}}, bucket_bits_reg};
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign found_handle = found_handle_reg;

    // decide the outcome once every way of the bucket has been seen
    always_comb
    begin
        dec_status = ST_NOT_FOUND;
        dec_handle = '0;
        dec_we     = 1'b0;
        dec_way    = hit_way_reg;
        dec_slot   = '0;
        if (req_reg == REQ_ADD)
        begin
            if (hit_reg)
            begin
                dec_status = ST_DUPLICATE;
            end
            else if (free_reg)
            begin
                dec_status      = ST_OK;
                dec_we          = 1'b1;
                dec_way         = free_way_reg;
                dec_slot.valid  = 1'b1;
                dec_slot.key    = key_reg;
                dec_slot.handle = handle_reg;
            end
            else
            begin
                dec_status = ST_FULL;
            end
        end
        else if (hit_reg)
        begin
            dec_status = ST_OK;
            dec_handle = hit_handle_reg;
            dec_we     = req_reg == REQ_REMOVE;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = IS_POW2 ? S_READ : S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = way_last ? S_DECIDE : S_READ;
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = base_addr + ADDR_W'(way_reg);
        ram_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_cnt_reg;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_DECIDE:
            begin
                ram_we    = dec_we && out_free;
                ram_addr  = base_addr + ADDR_W'(dec_way);
                ram_wdata = dec_slot;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        clr_cnt_next      = clr_cnt_reg;
        req_next          = req_reg;
        key_next          = key_reg;
        handle_next       = handle_reg;
        mkey_next         = mkey_reg;
        quot_next         = quot_reg;
        mod_cnt_next      = mod_cnt_reg;
        bucket_next       = bucket_reg;
        way_next          = way_reg;
        hit_next          = hit_reg;
        hit_way_next      = hit_way_reg;
        hit_handle_next   = hit_handle_reg;
        free_next         = free_reg;
        free_way_next     = free_way_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        status_next       = status_reg;
        found_handle_next = found_handle_reg;
        bucket_bits_next  = cfg_write && !paddr[2] ? pwdata[BB_W-1:0] : bucket_bits_reg;

        if (state_reg == S_CLEAR)
        begin
            clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
        end

        if (in_fire)
        begin
            req_next     = req_type;
            key_next     = key;
            handle_next  = object_handle;
            mkey_next    = in_mkey;
            mod_cnt_next = '0;
            bucket_next  = BKT_W'(in_mkey) & BKT_W'(MAX_BUCKETS - 1);
            way_next     = '0;
            hit_next     = 1'b0;
            free_next    = 1'b0;
        end

        // estimate the quotient by reciprocal multiply, then correct the remainder once
        if (state_reg == S_MOD)
        begin
            mod_cnt_next = mod_cnt_reg + MC_W'(1);
            if (!mod_done)
            begin
                quot_next = mod_prod[MKEY_W+31:32];
            end
            else
            begin
                bucket_next = BKT_W'(mod_rem);
            end
        end

        if (state_reg == S_CMP)
        begin
            if (slot_match && !hit_reg)
            begin
                hit_next        = 1'b1;
                hit_way_next    = way_reg;
                hit_handle_next = ram_rdata.handle;
            end
            if (!ram_rdata.valid && !free_reg)
            begin
                free_next     = 1'b1;
                free_way_next = way_reg;
            end
            if (!way_last)
            begin
                way_next = way_reg + WAY_W'(1);
            end
        end

        if (state_reg == S_DECIDE && out_free)
        begin
            out_valid_next    = 1'b1;
            status_next       = dec_status;
            found_handle_next = dec_handle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_cnt_reg      <= '0;
            mod_cnt_reg      <= '0;
            way_reg          <= '0;
            hit_reg          <= 1'b0;
            free_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            bucket_bits_reg  <= BB_W'(BB_RESET);
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            mod_cnt_reg      <= mod_cnt_next;
            way_reg          <= way_next;
            hit_reg          <= hit_next;
            free_reg         <= free_next;
            out_valid_reg    <= out_valid_next;
            bucket_bits_reg  <= bucket_bits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg          <= req_next;
        key_reg          <= key_next;
        handle_reg       <= handle_next;
        mkey_reg         <= mkey_next;
        quot_reg         <= quot_next;
        bucket_reg       <= bucket_next;
        hit_way_reg      <= hit_way_next;
        hit_handle_reg   <= hit_handle_next;
        free_way_reg     <= free_way_next;
        status_reg       <= status_next;
        found_handle_reg <= found_handle_next;
    end

    a_out_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DECIDE))
        else $error("result word raised outside the decide step");

    a_ram_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_DECIDE))
        else $error("slot store written outside clear or decide");

    a_miss_zero_handle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |-> found_handle_reg == '0)
        else $error("nonzero handle on a failed request");

    a_way_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ || state_reg == S_CMP) |-> way_reg <= WAY_W'(WAYS - 1))
        else $error("way counter beyond the bucket");

endmodule

FILE: bench/bkom_checker.sv
`timescale 1ns / 1ps
// Reply checker for bucketed_key_object_map: watches the request, reply and register buses,
// keeps its own slot store and bucket_bits copy, predicts each reply and compares it.
// Depends on bkom_pkg.
module bkom_checker
    import bkom_pkg::*;
#(
    parameter logic [2:0] BUCKET_BITS_ADDR = 3'd0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [1:0]          req_type,
    input  logic [KEY_W-1:0]    key,
    input  logic [HANDLE_W-1:0] object_handle,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [1:0]          status,
    input  logic [HANDLE_W-1:0] found_handle,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output int                  outstanding,
    output int                  mismatches,
    output int                  replies_checked
);

    localparam int SLOTS      = MAX_BUCKETS_DEF * WAYS_DEF;

    typedef struct packed {
        logic [1:0]          status;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
    } reply_t;

    logic                slot_live   [SLOTS];
    logic [KEY_W-1:0]    slot_key_r  [SLOTS];
    logic [HANDLE_W-1:0] slot_obj    [SLOTS];
    logic [BB_W-1:0]     map_bits;
    reply_t              replies_due [$];
    reply_t              due;
    reply_t              fresh;
    int                  fail_tally;
    int                  seen_tally;

    function automatic int bucket_base(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] mask;
        mask = (32'd1 << map_bits) - 32'd1;
        return ((k & mask) % MAX_BUCKETS_DEF) * WAYS_DEF;
    endfunction

    task automatic resolve_request(input logic [1:0] op, input logic [KEY_W-1:0] k,
                                   input logic [HANDLE_W-1:0] h, output reply_t r);
        int base;
        int hit;
        int w;
        base = bucket_base(k);
        hit = -1;
        for (w = 0; w < WAYS_DEF; w++)
        begin
            if (hit < 0 && slot_live[base + w] && slot_key_r[base + w] == k)
                hit = base + w;
        end
        r.key = k;
        r.status = ST_NOT_FOUND;
        r.handle = '0;
        if (op == REQ_ADD)
        begin
            if (hit >= 0)
                r.status = ST_DUPLICATE;
            else
            begin
                r.status = ST_FULL;
                for (w = 0; w < WAYS_DEF && r.status == ST_FULL; w++)
                begin
                    if (!slot_live[base + w])
                    begin
                        slot_live[base + w] = 1'b1;
                        slot_key_r[base + w] = k;
                        slot_obj[base + w] = h;
                        r.status = ST_OK;
                    end
                end
            end
        end
        else if (hit >= 0)
        begin
            r.status = ST_OK;
            r.handle = slot_obj[hit];
            if (op == REQ_REMOVE)
                slot_live[hit] = 1'b0;
        end
    endtask

    task automatic report(input string what, input logic [KEY_W-1:0] k,
                          input logic [31:0] wanted, input logic [31:0] actual);
        fail_tally++;
        $display("%0t: %s mismatch for key %h: expected %h, actual %h",
                 $time, what, k, wanted, actual);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
                slot_live[s] = 1'b0;
            map_bits = BB_W'(BB_RESET);
            replies_due.delete();
            fail_tally = 0;
            seen_tally = 0;
            outstanding <= 0;
            mismatches <= 0;
            replies_checked <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen_tally++;
                if (replies_due.size() == 0)
                    report("unexpected word", '0, '0, {30'd0, status});
                else
                begin
                    due = replies_due.pop_front();
                    if (status !== due.status)
                        report("status", due.key, {30'd0, due.status}, {30'd0, status});
                    if (found_handle !== due.handle)
                        report("found_handle", due.key, due.handle, found_handle);
                end
            end
            if (in_valid && in_ready)
            begin
                resolve_request(req_type, key, object_handle, fresh);
                replies_due.push_back(fresh);
            end
            if (psel && penable && pwrite && pready && paddr[2] == BUCKET_BITS_ADDR[2])
                map_bits = pwdata[BB_W-1:0];
            outstanding <= replies_due.size();
            mismatches <= fail_tally;
            replies_checked <= seen_tally;
        end
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Top of the bucketed_key_object_map bench: clock, reset, request and register stimulus,
// randomized stalls on both channels and the verdict. Depends on bkom_pkg, bkom_checker
// and the block itself.
module tb
    import bkom_pkg::*;
();

    localparam logic [2:0] BUCKET_BITS_ADDR = 3'd0;
    localparam logic [1:0] REQ_SPARE        = 2'd3;
    localparam int SETTLE_CYCLES = 2 * WAYS_DEF + 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 9;
    localparam int PHASE_WORDS   = 160;
    localparam int POOL_SIZE     = 20;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [1:0]          req_type = REQ_FIND;
    logic [KEY_W-1:0]    key = '0;
    logic [HANDLE_W-1:0] object_handle = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [1:0]          status;
    logic [HANDLE_W-1:0] found_handle;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int words_sent = 0;
    int settings_used = 0;
    int outstanding;
    int mismatches;
    int replies_checked;

    logic [BB_W-1:0] phase_bits [PHASES] = '{4'd0, 4'd15, 4'd4, 4'd8, 4'd1, 4'd12, 4'd9,
                                             4'd2, 4'd8};

    bucketed_key_object_map uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .key           (key),
        .object_handle (object_handle),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .found_handle  (found_handle),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    bkom_checker #(
        .BUCKET_BITS_ADDR (BUCKET_BITS_ADDR)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .key             (key),
        .object_handle   (object_handle),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .found_handle    (found_handle),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .outstanding     (outstanding),
        .mismatches      (mismatches),
        .replies_checked (replies_checked)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("bucketed_key_object_map regression: fail");
        $finish;
    end

    // hold off the reply channel for a long stretch whenever asked
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_asked)
        begin
            hold_seen <= hold_asked;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_word(input logic [1:0] op, input logic [KEY_W-1:0] k,
                             input logic [HANDLE_W-1:0] h);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= op;
        key <= k;
        object_handle <= h;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_bucket_bits(input logic [BB_W-1:0] bits);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= BUCKET_BITS_ADDR;
        pwdata <= {28'($urandom), bits};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input logic [BB_W-1:0] bits, input bit long_hold,
                             input bit full_pause);
        logic [KEY_W-1:0] pool [POOL_SIZE];
        logic [KEY_W-1:0] k;
        logic [1:0]       op;
        int               i;
        int               pick;
        drain();
        write_bucket_bits(bits);
        // crowd keys into a few buckets so hits, duplicates and full buckets occur
        for (i = 0; i < POOL_SIZE; i++)
            pool[i] = ($urandom & 32'hFFFF_FF00) | 32'($urandom_range(5));
        for (i = 0; i < PHASE_WORDS; i++)
        begin
            if (long_hold && i == 20)
                hold_asked <= hold_asked + 1;
            if (full_pause && i == PHASE_WORDS / 2)
                drain();
            if ($urandom_range(99) < 80)
                k = pool[$urandom_range(POOL_SIZE - 1)];
            else
                k = $urandom;
            pick = $urandom_range(99);
            if (pick < 40)
                op = REQ_ADD;
            else if (pick < 70)
                op = REQ_FIND;
            else if (pick < 95)
                op = REQ_REMOVE;
            else
                op = REQ_SPARE;
            send_word(op, k, $urandom);
        end
    endtask

    initial
    begin
        int p;
        send_idle_pct = 36;
        recv_idle_pct <= 71;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_word(REQ_FIND,   32'h0000_0000, 32'h0000_0000);
        send_word(REQ_REMOVE, 32'hDEAD_BE00, 32'h0000_0000);
        send_word(REQ_ADD,    32'h0000_0000, 32'hFFFF_FFFF);
        send_word(REQ_ADD,    32'h0000_0000, 32'h0000_1234);
        send_word(REQ_FIND,   32'h0000_0000, 32'h0000_0000);
        send_word(REQ_ADD,    32'h0000_0100, 32'hA5A5_A5A5);
        send_word(REQ_ADD,    32'h8000_0200, 32'h5A5A_5A5A);
        send_word(REQ_ADD,    32'hFFFF_FF00, 32'h0000_0001);
        send_word(REQ_ADD,    32'h0000_0400, 32'h0000_0002);
        send_word(REQ_ADD,    32'h0000_0100, 32'h0000_0000);
        send_word(REQ_SPARE,  32'h8000_0200, 32'hFFFF_FFFF);
        send_word(REQ_REMOVE, 32'h8000_0200, 32'h0000_0000);
        send_word(REQ_FIND,   32'h8000_0200, 32'h0000_0000);
        send_word(REQ_ADD,    32'h0000_0400, 32'h8000_0000);
        send_word(REQ_ADD,    32'hFFFF_FFFF, 32'h0000_0000);
        send_word(REQ_FIND,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(REQ_SPARE,  32'h7777_7777, 32'h0000_0000);
        send_word(REQ_REMOVE, 32'h0000_0000, 32'h0000_0000);
        send_word(REQ_REMOVE, 32'h0000_0000, 32'h0000_0000);
        send_word(REQ_FIND,   32'hFFFF_FF00, 32'h0000_0000);

        for (p = 0; p < PHASES; p++)
        begin
            if (p == 3)
            begin
                send_idle_pct = 71;
                recv_idle_pct <= 36;
            end
            if (p == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            run_phase(phase_bits[p], p == 1, p == 4);
        end
        drain();

        $display("covered %0d requests and %0d checked replies across %0d bucket_bits writes,",
                 words_sent, replies_checked, settings_used);
        $display("including bucket_bits 0 and 15, full buckets, duplicates and a long stall");
        if (mismatches == 0)
            $display("bucketed_key_object_map regression: pass");
        else
            $display("bucketed_key_object_map regression: fail");
        $finish;
    end

endmodule
